// ----- rtl/core/lbrs_pkg.sv -----
// Package for the repeated-square-root logarithm block.
// Holds status codes and fixed constants; no dependencies.
`default_nettype none

package lbrs_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_NOCONV  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_TOL  = 2'd1;

  // Width of one multiplier partial-product slice.
  localparam int unsigned CHUNK_W = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] BASE_RST = 16'd10;
  localparam logic [31:0] TOL_RST  = 32'd1;

endpackage

`default_nettype wire

// ----- rtl/core/lbrs_sqrt.sv -----
// Serial restoring square root, one result bit per cycle.
// Uses lbrs_pkg; instantiated by the top level for the root table build.
`default_nettype none

module lbrs_sqrt
  import lbrs_pkg::*;
#(
  parameter int unsigned RAD_W = 80
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [RAD_W-1:0]     rad_i,
  output logic                      done_o,
  output logic [RAD_W/2-1:0]        root_o
);

  localparam int unsigned H   = RAD_W / 2;
  localparam int unsigned CW  = $clog2(H + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [H+1:0]     rem_q, rem_d;
  logic [H-1:0]     root_q, root_d;
  logic [H+2:0]     rem_sh;
  logic [H+2:0]     trial;

  // One radicand digit pair enters the partial remainder each cycle while busy.
  always_comb begin
    rem_sh = {rem_q[H:0], rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        rad_d  = rad_i;
        rem_d  = '0;
        root_d = '0;
      end
    end else begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = (H+2)'(rem_sh - trial);
        root_d = {root_q[H-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[H+1:0];
        root_d = {root_q[H-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(H - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ----- rtl/core/lbrs_cell.sv -----
// One cell of the root chain: holds a table entry and passes it on.
// Uses lbrs_pkg; instantiated in a row by the top level.
`default_nettype none

module lbrs_cell
  import lbrs_pkg::*;
#(
  parameter int unsigned W = 48
) (
  input  wire logic         clk_i,
  input  wire logic         shift_i,
  input  wire logic [W-1:0] d_i,
  output logic [W-1:0]      q_o
);

  logic [W-1:0] val_q;

  // Take the neighbor's entry whenever the chain moves.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

`default_nettype wire

// ----- rtl/core/log_by_repeated_square_roots.sv -----
// Fractional log to an integer base of an unsigned Q16.16 word, one bit per step.
// The roots base^(1/2^k) live in a ring of cells that rotates by one entry per
// step, so the current root always sits at the head. A step multiplies the
// running product by the head root in 16-bit slices, top slice first, then
// keeps or drops the product and checks its closeness to the argument. Once
// the steps end, the ring is turned on by one entry per unused step back to
// its home position, and an out-of-range word skips the steps entirely. After
// reset and after every base write the ring is rebuilt by a serial square-root
// unit, one root per cell (FRAC_BITS roots), during which no word is accepted.
// Depends on lbrs_pkg, lbrs_sqrt and lbrs_cell.
`default_nettype none

module log_by_repeated_square_roots
  import lbrs_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 24,
  parameter int unsigned ROOT_WIDTH = 48
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [31:0]                       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [31:0]                       x_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             status_o,
  output logic [FRAC_BITS-1:0]                   log_fraction_o,
  output logic [FRAC_BITS-1:0]                   numerator_o,
  output logic [FRAC_BITS:0]                     denominator_o,
  output logic [$clog2(FRAC_BITS+1)-1:0]         steps_o
);

  localparam int unsigned RF    = ROOT_WIDTH - 16;
  localparam int unsigned RAD_W = ROOT_WIDTH + RF;
  localparam int unsigned HALF  = RAD_W / 2;
  localparam int unsigned NCH   = (ROOT_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned PADW  = NCH * CHUNK_W;
  localparam int unsigned AW    = ROOT_WIDTH + PADW;
  localparam int unsigned SW    = $clog2(FRAC_BITS + 1);
  localparam int unsigned MW    = $clog2(NCH);

  localparam logic [2:0] S_BUILD = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_KEEP  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_ALIGN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [15:0]           base_q, base_d;
  logic [31:0]           tol_q, tol_d;
  logic                  bld_run_q, bld_run_d;
  logic [SW-1:0]         bld_cnt_q, bld_cnt_d;
  logic [SW-1:0]         step_q, step_d;
  logic [SW-1:0]         rot_q, rot_d;
  logic [MW-1:0]         mcnt_q, mcnt_d;
  logic [ROOT_WIDTH-1:0] xs_q, xs_d;
  logic [ROOT_WIDTH-1:0] v_q, v_d;
  logic [AW-1:0]         acc_q, acc_d;
  logic [FRAC_BITS-1:0]  frac_q, frac_d;
  logic [1:0]            stat_q, stat_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_stat_q;
  logic [FRAC_BITS-1:0]  out_frac_q;
  logic [FRAC_BITS-1:0]  out_num_q;
  logic [FRAC_BITS:0]    out_den_q;
  logic [SW-1:0]         out_steps_q;
  logic                  out_load;

  logic                  sq_start, sq_done;
  logic [RAD_W-1:0]      sq_rad;
  logic [HALF-1:0]       sq_root;

  logic                  chain_shift;
  logic [ROOT_WIDTH-1:0] chain_in;
  logic [ROOT_WIDTH-1:0] cell_q [FRAC_BITS];

  logic                  in_acc, cfg_acc;
  logic [PADW-1:0]       root_pad;
  logic [CHUNK_W-1:0]    chunk;
  logic [ROOT_WIDTH+CHUNK_W-1:0] pp;
  logic                  keep;
  logic [ROOT_WIDTH-1:0] diff;
  logic                  conv;

  // Handshakes: configuration wins a tie with an input word.
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;

  // Square-root unit for the table build.
  assign sq_start = (state_q == S_BUILD) && !bld_run_q;
  assign sq_rad   = (bld_cnt_q == '0) ? (RAD_W'(base_q) << (2 * RF))
                                      : (RAD_W'(cell_q[FRAC_BITS-1]) << RF);

  lbrs_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (sq_rad),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // Root ring: entries move toward the head; the head wraps to the tail.
  assign chain_in = (state_q == S_BUILD) ? ROOT_WIDTH'(sq_root) : cell_q[0];

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    if (i == FRAC_BITS - 1) begin : g_tail
      lbrs_cell #(.W(ROOT_WIDTH)) u_cell (
        .clk_i  (clk_i),
        .shift_i(chain_shift),
        .d_i    (chain_in),
        .q_o    (cell_q[i])
      );
    end else begin : g_body
      lbrs_cell #(.W(ROOT_WIDTH)) u_cell (
        .clk_i  (clk_i),
        .shift_i(chain_shift),
        .d_i    (cell_q[i+1]),
        .q_o    (cell_q[i])
      );
    end
  end

  // Multiply datapath: one 16-bit slice of the head root per cycle, top first.
  assign root_pad = PADW'(cell_q[0]);
  assign chunk    = root_pad[mcnt_q*CHUNK_W +: CHUNK_W];
  assign pp       = v_q * chunk;
  assign keep     = (acc_q >> RF) <= AW'(xs_q);

  // Closeness of the running product to the argument.
  assign diff = (v_q > xs_q) ? (v_q - xs_q) : (xs_q - v_q);
  assign conv = (diff == '0) || ((diff >> (RF - 16)) < ROOT_WIDTH'(tol_q));

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    tol_d       = tol_q;
    bld_run_d   = bld_run_q;
    bld_cnt_d   = bld_cnt_q;
    step_d      = step_q;
    rot_d       = rot_q;
    mcnt_d      = mcnt_q;
    xs_d        = xs_q;
    v_d         = v_q;
    acc_d       = acc_q;
    frac_d      = frac_q;
    stat_d      = stat_q;
    chain_shift = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_BUILD: begin
        if (sq_start) begin
          bld_run_d = 1'b1;
        end
        if (sq_done) begin
          chain_shift = 1'b1;
          bld_run_d   = 1'b0;
          bld_cnt_d   = bld_cnt_q + 1'b1;
          if (bld_cnt_q == SW'(FRAC_BITS - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (cfg_acc) begin
          if (cfg_index_i == REG_BASE) begin
            base_d    = cfg_data_i[15:0];
            bld_cnt_d = '0;
            bld_run_d = 1'b0;
            state_d   = S_BUILD;
          end else if (cfg_index_i == REG_TOL) begin
            tol_d = cfg_data_i;
          end
        end else if (in_acc) begin
          xs_d   = ROOT_WIDTH'(x_value_i) << (RF - 16);
          v_d    = ROOT_WIDTH'(1) << RF;
          frac_d = '0;
          step_d = '0;
          rot_d  = '0;
          acc_d  = '0;
          mcnt_d = MW'(NCH - 1);
          if ((x_value_i[31:16] == 16'd0) || (x_value_i[31:16] >= base_q)) begin
            stat_d  = ST_RANGE;
            state_d = S_DONE;
          end else begin
            stat_d  = ST_NOCONV;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        acc_d  = (acc_q << CHUNK_W) + AW'(pp);
        mcnt_d = mcnt_q - 1'b1;
        if (mcnt_q == '0) begin
          state_d = S_KEEP;
        end
      end
      S_KEEP: begin
        if (keep) begin
          v_d    = acc_q[RF +: ROOT_WIDTH];
          frac_d = frac_q | (FRAC_BITS'(1) << (SW'(FRAC_BITS - 1) - step_q));
        end
        step_d      = step_q + 1'b1;
        rot_d       = rot_q + 1'b1;
        chain_shift = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        acc_d  = '0;
        mcnt_d = MW'(NCH - 1);
        if (conv) begin
          stat_d  = ST_OK;
          state_d = S_ALIGN;
        end else if (step_q == SW'(FRAC_BITS)) begin
          state_d = S_ALIGN;
        end else begin
          state_d = S_MUL;
        end
      end
      S_ALIGN: begin
        // Turn the ring back to its home position for the next word.
        if (rot_q == SW'(FRAC_BITS)) begin
          state_d = S_DONE;
        end else begin
          chain_shift = 1'b1;
          rot_d       = rot_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BUILD;
      base_q      <= BASE_RST;
      tol_q       <= TOL_RST;
      bld_run_q   <= 1'b0;
      bld_cnt_q   <= '0;
      step_q      <= '0;
      rot_q       <= '0;
      mcnt_q      <= '0;
      stat_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      tol_q       <= tol_d;
      bld_run_q   <= bld_run_d;
      bld_cnt_q   <= bld_cnt_d;
      step_q      <= step_d;
      rot_q       <= rot_d;
      mcnt_q      <= mcnt_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    xs_q   <= xs_d;
    v_q    <= v_d;
    acc_q  <= acc_d;
    frac_q <= frac_d;
    if (out_load) begin
      out_stat_q  <= stat_q;
      out_frac_q  <= frac_q;
      out_num_q   <= frac_q >> (SW'(FRAC_BITS) - step_q);
      out_den_q   <= (FRAC_BITS+1)'(1) << step_q;
      out_steps_q <= step_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_stat_q;
  assign log_fraction_o = out_frac_q;
  assign numerator_o    = out_num_q;
  assign denominator_o  = out_den_q;
  assign steps_o        = out_steps_q;

endmodule

`default_nettype wire
